### rtl/ract_pkg.sv
package ract_pkg;

   localparam int DefEntries   = 64;
   localparam int DefAddrBits  = 48;
   localparam int DefCountBits = 32;
   localparam int IdBits       = 32;
   localparam int KindBits     = 2;
   localparam int StatusBits   = 3;

   localparam logic [KindBits-1:0] KIND_REGISTER   = 2'd0;
   localparam logic [KindBits-1:0] KIND_ACCESS     = 2'd1;
   localparam logic [KindBits-1:0] KIND_UNREGISTER = 2'd2;

   localparam logic [StatusBits-1:0] ST_REGISTERED = 3'd0;
   localparam logic [StatusBits-1:0] ST_HIT        = 3'd1;
   localparam logic [StatusBits-1:0] ST_MISS       = 3'd2;
   localparam logic [StatusBits-1:0] ST_RECORD     = 3'd3;
   localparam logic [StatusBits-1:0] ST_NOT_FOUND  = 3'd4;
   localparam logic [StatusBits-1:0] ST_FULL       = 3'd5;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_BUMP  = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   typedef struct packed {
      logic       en;
      logic [1:0] op;
      logic       wr;
   } cmd_type;

endpackage

### rtl/ract_if.sv
interface ract_req_if #(parameter int ADDR_BITS = 48);
   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   logic [ADDR_BITS-1:0] address;
   logic [ADDR_BITS-1:0] region_size;
   logic [31:0]          region_id;
   logic                 write_access;
   modport source (output valid, req_type, address, region_size, region_id, write_access,
                   input ready);
   modport sink (input valid, req_type, address, region_size, region_id, write_access,
                 output ready);
endinterface

interface ract_rsp_if #(parameter int ADDR_BITS = 48, parameter int COUNT_BITS = 32);
   logic                  valid;
   logic                  ready;
   logic [2:0]            status;
   logic [31:0]           out_id;
   logic [ADDR_BITS-1:0]  out_base;
   logic [ADDR_BITS-1:0]  out_size;
   logic [COUNT_BITS-1:0] out_reads;
   logic [COUNT_BITS-1:0] out_writes;
   modport source (output valid, status, out_id, out_base, out_size, out_reads, out_writes,
                   input ready);
   modport sink (input valid, status, out_id, out_base, out_size, out_reads, out_writes,
                 output ready);
endinterface

### rtl/region_access_counter_table.sv
// A request is accepted only in idle; the lookup then ripples through the chain
// of entry cells, one cell per cycle, and the response is held until it is
// taken, after which the block returns to idle. No new request is accepted
// while one is in progress.
// Reset clears every entry valid bit and the control state; no clearing pass.
module region_access_counter_table
   import ract_pkg::*;
#(
   parameter int ENTRIES    = DefEntries,
   parameter int ADDR_BITS  = DefAddrBits,
   parameter int COUNT_BITS = DefCountBits
) (
   input logic clock,
   input logic reset,
   ract_req_if.sink   req_ch,
   ract_rsp_if.source rsp_ch
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        cnt_ff;
   logic [KindBits-1:0]  kind_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [ADDR_BITS-1:0] size_ff;
   logic [IdBits-1:0]    id_ff;
   logic                 wr_ff;

   logic                  m_hit  [ENTRIES+1];
   logic [IW-1:0]         m_idx  [ENTRIES+1];
   logic [IdBits-1:0]     m_tag  [ENTRIES+1];
   logic [ADDR_BITS-1:0]  m_len  [ENTRIES+1];
   logic [COUNT_BITS-1:0] m_rd   [ENTRIES+1];
   logic [COUNT_BITS-1:0] m_wr   [ENTRIES+1];
   logic                  f_hit  [ENTRIES+1];
   logic [IW-1:0]         f_idx  [ENTRIES+1];
   logic                  b_hit  [ENTRIES+1];
   logic [IW-1:0]         b_idx  [ENTRIES+1];
   logic [ADDR_BITS-1:0]  b_base [ENTRIES+1];
   logic [ADDR_BITS-1:0]  b_len  [ENTRIES+1];

   cmd_type               cmd;
   logic [IW-1:0]         cmd_idx;
   logic                  done;
   logic                  in_region;
   logic [StatusBits-1:0] status_in;

   assign m_hit[0]  = 1'b0;
   assign m_idx[0]  = '0;
   assign m_tag[0]  = '0;
   assign m_len[0]  = '0;
   assign m_rd[0]   = '0;
   assign m_wr[0]   = '0;
   assign f_hit[0]  = 1'b0;
   assign f_idx[0]  = '0;
   assign b_hit[0]  = 1'b0;
   assign b_idx[0]  = '0;
   assign b_base[0] = '0;
   assign b_len[0]  = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      ract_cell #(
         .ENTRIES(ENTRIES), .ADDR_BITS(ADDR_BITS), .COUNT_BITS(COUNT_BITS), .IDX(g)
      ) u_cell (
         .clock, .reset,
         .addr(addr_ff), .size(size_ff), .id(id_ff), .cmd, .cmd_idx,
         .m_hit_i(m_hit[g]), .m_idx_i(m_idx[g]), .m_tag_i(m_tag[g]),
         .m_len_i(m_len[g]), .m_rd_i(m_rd[g]), .m_wr_i(m_wr[g]),
         .f_hit_i(f_hit[g]), .f_idx_i(f_idx[g]),
         .b_hit_i(b_hit[g]), .b_idx_i(b_idx[g]), .b_base_i(b_base[g]), .b_len_i(b_len[g]),
         .m_hit_ff(m_hit[g+1]), .m_idx_ff(m_idx[g+1]), .m_tag_ff(m_tag[g+1]),
         .m_len_ff(m_len[g+1]), .m_rd_ff(m_rd[g+1]), .m_wr_ff(m_wr[g+1]),
         .f_hit_ff(f_hit[g+1]), .f_idx_ff(f_idx[g+1]),
         .b_hit_ff(b_hit[g+1]), .b_idx_ff(b_idx[g+1]),
         .b_base_ff(b_base[g+1]), .b_len_ff(b_len[g+1])
      );
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = (state_ff == S_RESP);
   assign done      = (state_ff == S_SCAN) && (cnt_ff == CW'(ENTRIES));
   assign in_region = b_hit[ENTRIES] && ((addr_ff - b_base[ENTRIES]) < b_len[ENTRIES]);

   always_comb begin
      cmd.en    = 1'b0;
      cmd.op    = OP_WRITE;
      cmd.wr    = wr_ff;
      cmd_idx   = '0;
      status_in = ST_NOT_FOUND;
      case (kind_ff)
         KIND_REGISTER: begin
            if (m_hit[ENTRIES]) begin
               cmd.en    = done;
               cmd_idx   = m_idx[ENTRIES];
               status_in = ST_REGISTERED;
            end else if (f_hit[ENTRIES]) begin
               cmd.en    = done;
               cmd_idx   = f_idx[ENTRIES];
               status_in = ST_REGISTERED;
            end else begin
               status_in = ST_FULL;
            end
         end
         KIND_ACCESS: begin
            cmd.op  = OP_BUMP;
            cmd_idx = b_idx[ENTRIES];
            if (in_region) begin
               cmd.en    = done;
               status_in = ST_HIT;
            end else begin
               status_in = ST_MISS;
            end
         end
         KIND_UNREGISTER: begin
            cmd.op  = OP_FREE;
            cmd_idx = m_idx[ENTRIES];
            if (m_hit[ENTRIES]) begin
               cmd.en    = done;
               status_in = ST_RECORD;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_ch.valid) state_in = S_SCAN;
         S_SCAN:  if (done) state_in = S_RESP;
         S_RESP:  if (rsp_ch.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= (state_ff == S_SCAN) ? cnt_ff + 1'b1 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         kind_ff <= req_ch.req_type;
         addr_ff <= req_ch.address;
         size_ff <= req_ch.region_size;
         id_ff   <= req_ch.region_id;
         wr_ff   <= req_ch.write_access;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ch.status <= status_in;
         if (status_in == ST_RECORD) begin
            rsp_ch.out_id     <= m_tag[ENTRIES];
            rsp_ch.out_base   <= addr_ff;
            rsp_ch.out_size   <= m_len[ENTRIES];
            rsp_ch.out_reads  <= m_rd[ENTRIES];
            rsp_ch.out_writes <= m_wr[ENTRIES];
         end else begin
            rsp_ch.out_id     <= '0;
            rsp_ch.out_base   <= '0;
            rsp_ch.out_size   <= '0;
            rsp_ch.out_reads  <= '0;
            rsp_ch.out_writes <= '0;
         end
      end
   end

endmodule

### rtl/ract_cell.sv
module ract_cell
   import ract_pkg::*;
#(
   parameter int ENTRIES    = DefEntries,
   parameter int ADDR_BITS  = DefAddrBits,
   parameter int COUNT_BITS = DefCountBits,
   parameter int IDX        = 0,
   localparam int IW        = $clog2(ENTRIES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ADDR_BITS-1:0]  addr,
   input  logic [ADDR_BITS-1:0]  size,
   input  logic [IdBits-1:0]     id,
   input  cmd_type               cmd,
   input  logic [IW-1:0]         cmd_idx,
   input  logic                  m_hit_i,
   input  logic [IW-1:0]         m_idx_i,
   input  logic [IdBits-1:0]     m_tag_i,
   input  logic [ADDR_BITS-1:0]  m_len_i,
   input  logic [COUNT_BITS-1:0] m_rd_i,
   input  logic [COUNT_BITS-1:0] m_wr_i,
   input  logic                  f_hit_i,
   input  logic [IW-1:0]         f_idx_i,
   input  logic                  b_hit_i,
   input  logic [IW-1:0]         b_idx_i,
   input  logic [ADDR_BITS-1:0]  b_base_i,
   input  logic [ADDR_BITS-1:0]  b_len_i,
   output logic                  m_hit_ff,
   output logic [IW-1:0]         m_idx_ff,
   output logic [IdBits-1:0]     m_tag_ff,
   output logic [ADDR_BITS-1:0]  m_len_ff,
   output logic [COUNT_BITS-1:0] m_rd_ff,
   output logic [COUNT_BITS-1:0] m_wr_ff,
   output logic                  f_hit_ff,
   output logic [IW-1:0]         f_idx_ff,
   output logic                  b_hit_ff,
   output logic [IW-1:0]         b_idx_ff,
   output logic [ADDR_BITS-1:0]  b_base_ff,
   output logic [ADDR_BITS-1:0]  b_len_ff
);

   localparam logic [IW-1:0] MyIdx = IW'(IDX);

   logic                  valid_ff;
   logic [ADDR_BITS-1:0]  base_ff;
   logic [ADDR_BITS-1:0]  len_ff;
   logic [IdBits-1:0]     tag_ff;
   logic [COUNT_BITS-1:0] rd_ff;
   logic [COUNT_BITS-1:0] wr_ff;
   logic                  sel;
   logic                  take_m;
   logic                  take_f;
   logic                  take_b;

   assign sel    = cmd.en && (cmd_idx == MyIdx);
   assign take_m = !m_hit_i && valid_ff && (base_ff == addr);
   assign take_f = !f_hit_i && !valid_ff;
   assign take_b = valid_ff && (base_ff <= addr) && (!b_hit_i || (base_ff > b_base_i));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel) begin
         case (cmd.op)
            OP_WRITE: valid_ff <= 1'b1;
            OP_FREE:  valid_ff <= 1'b0;
            default:  valid_ff <= valid_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         case (cmd.op)
            OP_WRITE: begin
               base_ff <= addr;
               len_ff  <= size;
               tag_ff  <= id;
               rd_ff   <= '0;
               wr_ff   <= '0;
            end
            OP_BUMP: begin
               if (cmd.wr && !(&wr_ff)) wr_ff <= wr_ff + 1'b1;
               if (!cmd.wr && !(&rd_ff)) rd_ff <= rd_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_hit_ff <= 1'b0;
         f_hit_ff <= 1'b0;
         b_hit_ff <= 1'b0;
      end else begin
         m_hit_ff <= m_hit_i || take_m;
         f_hit_ff <= f_hit_i || take_f;
         b_hit_ff <= b_hit_i || take_b;
      end
   end

   always_ff @(posedge clock) begin
      m_idx_ff  <= take_m ? MyIdx : m_idx_i;
      m_tag_ff  <= take_m ? tag_ff : m_tag_i;
      m_len_ff  <= take_m ? len_ff : m_len_i;
      m_rd_ff   <= take_m ? rd_ff : m_rd_i;
      m_wr_ff   <= take_m ? wr_ff : m_wr_i;
      f_idx_ff  <= take_f ? MyIdx : f_idx_i;
      b_idx_ff  <= take_b ? MyIdx : b_idx_i;
      b_base_ff <= take_b ? base_ff : b_base_i;
      b_len_ff  <= take_b ? len_ff : b_len_i;
   end

endmodule
